[rtl/core/lcc_pkg.sv]
`timescale 1ns / 1ps

package lcc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int FREQ_W     = 32;
    localparam int VEL_W      = 16;
    localparam int KEY_W      = 7;
    localparam int LEN_W      = 16;
    localparam int GAIN_W     = 17;
    localparam int GAIN_FRAC  = 16;
    localparam int SQ_W       = 2 * FREQ_W;
    localparam int DIV_CNT_W  = $clog2(FREQ_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};

    // Values held after reset.
    localparam logic [LEN_W-1:0]  RST_FADE_LENGTH = LEN_W'(240);
    localparam logic [GAIN_W-1:0] RST_FADE_STEP   = GAIN_W'(273);
    localparam logic              RST_QUIET       = 1'b0;
    localparam logic [FREQ_W-1:0] RST_FREQ        = FREQ_W'(1802240);
    localparam logic [VEL_W-1:0]  RST_VELOCITY    = VEL_W'(65535);
    localparam logic              RST_GLIDE       = 1'b0;
    localparam logic [KEY_W-1:0]  RST_KEY         = KEY_W'(69);

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_FADE_IN  = 3'd1,
        MODE_FADE_OUT = 3'd2,
        MODE_CATCH_UP = 3'd3,
        MODE_TO_NORM  = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_LENGTH = 3'd0,
        CFG_FADE_STEP   = 3'd1,
        CFG_START_QUIET = 3'd2,
        CFG_INIT_FREQ   = 3'd3,
        CFG_INIT_VEL    = 3'd4,
        CFG_INIT_GLIDE  = 3'd5,
        CFG_INIT_KEY    = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SQUARE,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic load_item;
        logic decide;
        logic square;
        logic div_init;
        logic div_step;
        logic mul;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_catch;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

[rtl/core/lcc_channels.sv]
`timescale 1ns / 1ps

interface lcc_in_if #(
    parameter int SAMPLE_WIDTH = lcc_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [SAMPLE_WIDTH-1:0]    sample_left;
    logic signed [SAMPLE_WIDTH-1:0]    sample_right;
    logic [lcc_pkg::FREQ_W-1:0]        new_freq;
    logic [lcc_pkg::VEL_W-1:0]         new_velocity;
    logic                              new_glide;
    logic [lcc_pkg::KEY_W-1:0]         new_key;
    logic                              external;

    modport source (
        output valid, func, sample_left, sample_right, new_freq, new_velocity,
               new_glide, new_key, external,
        input  ready
    );

    modport sink (
        input  valid, func, sample_left, sample_right, new_freq, new_velocity,
               new_glide, new_key, external,
        output ready
    );
endinterface

interface lcc_out_if #(
    parameter int SAMPLE_WIDTH = lcc_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_WIDTH-1:0]    out_left;
    logic signed [SAMPLE_WIDTH-1:0]    out_right;
    logic                              fade_started;
    logic                              retrigger;
    logic [lcc_pkg::FREQ_W-1:0]        retrig_freq;
    logic [lcc_pkg::VEL_W-1:0]         retrig_velocity;
    logic                              retrig_glide;
    logic [lcc_pkg::KEY_W-1:0]         retrig_key;

    modport source (
        output valid, out_left, out_right, fade_started, retrigger, retrig_freq,
               retrig_velocity, retrig_glide, retrig_key,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right, fade_started, retrigger, retrig_freq,
               retrig_velocity, retrig_glide, retrig_key,
        output ready
    );
endinterface

[rtl/core/lcc_ctrl.sv]
`timescale 1ns / 1ps

module lcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lcc_pkg::status_t status,
    output lcc_pkg::cmd_t    cmd
);

    lcc_pkg::ctrl_state_t state_reg;
    lcc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lcc_pkg::ST_DECIDE;
                end
            end
            lcc_pkg::ST_DECIDE:
            begin
                state_next = status.need_catch ? lcc_pkg::ST_SQUARE : lcc_pkg::ST_MUL;
            end
            lcc_pkg::ST_SQUARE:
            begin
                state_next = lcc_pkg::ST_DIV_INIT;
            end
            lcc_pkg::ST_DIV_INIT:
            begin
                state_next = lcc_pkg::ST_DIV;
            end
            lcc_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = lcc_pkg::ST_MUL;
                end
            end
            lcc_pkg::ST_MUL:
            begin
                state_next = lcc_pkg::ST_FINISH;
            end
            lcc_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = lcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.load_item = in_valid;
            end
            lcc_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            lcc_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            lcc_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
            end
            lcc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            lcc_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            lcc_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/lcc_datapath.sv]
`timescale 1ns / 1ps

module lcc_datapath #(
    parameter int SAMPLE_WIDTH = lcc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcc_pkg::cmd_t                       cmd,
    output lcc_pkg::status_t                    status,

    input  logic                                func,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_left,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_right,
    input  logic [lcc_pkg::FREQ_W-1:0]          new_freq,
    input  logic [lcc_pkg::VEL_W-1:0]           new_velocity,
    input  logic                                new_glide,
    input  logic [lcc_pkg::KEY_W-1:0]           new_key,
    input  logic                                external,

    input  logic                                cfg_we,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcc_pkg::CFG_DATA_W-1:0]      cfg_data,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      out_left,
    output logic signed [SAMPLE_WIDTH-1:0]      out_right,
    output logic                                fade_started,
    output logic                                retrigger,
    output logic [lcc_pkg::FREQ_W-1:0]          retrig_freq,
    output logic [lcc_pkg::VEL_W-1:0]           retrig_velocity,
    output logic                                retrig_glide,
    output logic [lcc_pkg::KEY_W-1:0]           retrig_key
);

    localparam int FW    = lcc_pkg::FREQ_W;
    localparam int GW    = lcc_pkg::GAIN_W;
    localparam int PW    = SAMPLE_WIDTH + GW + 1;
    localparam int QW    = SAMPLE_WIDTH + 2;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Item registers
    logic                            item_func_reg;
    logic signed [SAMPLE_WIDTH-1:0]  item_left_reg;
    logic signed [SAMPLE_WIDTH-1:0]  item_right_reg;
    logic [FW-1:0]                   item_freq_reg;
    logic [lcc_pkg::VEL_W-1:0]       item_vel_reg;
    logic                            item_glide_reg;
    logic [lcc_pkg::KEY_W-1:0]       item_key_reg;
    logic                            item_ext_reg;

    // Voice state and configuration
    lcc_pkg::mode_t                  mode_reg, mode_next;
    logic                            muted_reg, muted_next;
    logic                            armed_reg, armed_next;
    logic [lcc_pkg::LEN_W-1:0]       phase_reg, phase_next;
    logic [GW-1:0]                   gain_reg, gain_next;
    logic [FW-1:0]                   held_freq_reg, held_freq_next;
    logic [lcc_pkg::VEL_W-1:0]       held_vel_reg, held_vel_next;
    logic                            held_glide_reg, held_glide_next;
    logic [lcc_pkg::KEY_W-1:0]       held_key_reg, held_key_next;
    logic [FW-1:0]                   prev_freq_reg, prev_freq_next;
    logic [lcc_pkg::LEN_W-1:0]       fade_length_reg, fade_length_next;
    logic [GW-1:0]                   fade_step_reg, fade_step_next;

    // Per-item decisions
    logic [GW-1:0]                   eff_gain_reg, eff_gain_next;
    logic                            fs_reg, fs_next;
    logic                            rt_reg, rt_next;
    logic                            rtc_reg, rtc_next;

    // Arithmetic
    logic [lcc_pkg::SQ_W-1:0]        sq_reg;
    logic [FW-1:0]                   rem_reg;
    logic [FW-1:0]                   low_reg;
    logic [FW-1:0]                   quot_reg;
    logic                            sat_reg;
    logic [lcc_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic signed [PW-1:0]            prod_left_reg;
    logic signed [PW-1:0]            prod_right_reg;
    logic                            out_valid_reg;

    logic                            out_valid_next;
    lcc_pkg::mode_t                  upd_mode;
    logic [lcc_pkg::LEN_W-1:0]       tick_count;
    logic                            tick_end;
    logic [lcc_pkg::LEN_W-1:0]       tick_rest;
    logic [GW:0]                     gain_sum;
    logic [GW-1:0]                   gain_up;
    logic [GW-1:0]                   gain_dn;
    logic                            sample_zero;
    logic [FW:0]                     div_shift;
    logic                            div_fits;
    logic [FW:0]                     div_diff;
    logic signed [GW:0]              gain_signed;
    logic [FW-1:0]                   catch_freq;

    function automatic logic signed [SAMPLE_WIDTH-1:0] clip(input logic signed [PW-1:0] prod);
        logic signed [QW-1:0] q;
        logic                 in_range;
        q        = prod[PW-1:lcc_pkg::GAIN_FRAC];
        in_range = (q[QW-1:SAMPLE_WIDTH-1] == '0) || (q[QW-1:SAMPLE_WIDTH-1] == '1);
        if (in_range)
        begin
            return q[SAMPLE_WIDTH-1:0];
        end
        return q[QW-1] ? SAMPLE_LO : SAMPLE_HI;
    endfunction

    assign upd_mode    = item_ext_reg ? lcc_pkg::MODE_NORMAL : mode_reg;
    assign tick_count  = armed_reg ? phase_reg : fade_length_reg;
    assign tick_end    = (tick_count <= lcc_pkg::LEN_W'(1));
    assign tick_rest   = tick_count - lcc_pkg::LEN_W'(1);
    assign gain_sum    = {1'b0, gain_reg} + {1'b0, fade_step_reg};
    assign gain_up     = (gain_sum > {1'b0, lcc_pkg::GAIN_MAX}) ? lcc_pkg::GAIN_MAX
                                                                : gain_sum[GW-1:0];
    assign gain_dn     = (gain_reg > fade_step_reg) ? (gain_reg - fade_step_reg) : '0;
    assign sample_zero = muted_reg && (mode_reg != lcc_pkg::MODE_FADE_IN);

    // One restoring division step: unless the quotient saturates, the remainder stays below the divisor.
    assign div_shift   = {rem_reg, low_reg[FW-1]};
    assign div_fits    = (div_shift >= {1'b0, prev_freq_reg});
    assign div_diff    = div_shift - {1'b0, prev_freq_reg};
    assign catch_freq  = sat_reg ? '1 : quot_reg;
    assign gain_signed = signed'({1'b0, eff_gain_reg});

    assign status.need_catch = item_func_reg && (mode_reg == lcc_pkg::MODE_FADE_OUT) && tick_end;
    assign status.div_last   = (div_cnt_reg == lcc_pkg::DIV_CNT_W'(FW - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        mode_next        = mode_reg;
        muted_next       = muted_reg;
        armed_next       = armed_reg;
        phase_next       = phase_reg;
        gain_next        = gain_reg;
        held_freq_next   = held_freq_reg;
        held_vel_next    = held_vel_reg;
        held_glide_next  = held_glide_reg;
        held_key_next    = held_key_reg;
        prev_freq_next   = prev_freq_reg;
        fade_length_next = fade_length_reg;
        fade_step_next   = fade_step_reg;
        eff_gain_next    = eff_gain_reg;
        fs_next          = fs_reg;
        rt_next          = rt_reg;
        rtc_next         = rtc_reg;

        if (cmd.decide)
        begin
            fs_next       = 1'b0;
            rt_next       = 1'b0;
            rtc_next      = 1'b0;
            eff_gain_next = '0;
            if (!item_func_reg)
            begin
                mode_next = upd_mode;
                if (upd_mode != lcc_pkg::MODE_CATCH_UP)
                begin
                    prev_freq_next  = held_freq_reg;
                    held_freq_next  = item_freq_reg;
                    held_vel_next   = item_vel_reg;
                    held_glide_next = item_glide_reg;
                    held_key_next   = item_key_reg;
                    if (upd_mode == lcc_pkg::MODE_NORMAL)
                    begin
                        if (muted_reg)
                        begin
                            gain_next = '0;
                            mode_next = lcc_pkg::MODE_FADE_IN;
                        end
                        else
                        begin
                            gain_next = lcc_pkg::GAIN_UNITY;
                            mode_next = lcc_pkg::MODE_FADE_OUT;
                            fs_next   = 1'b1;
                        end
                    end
                    else if (upd_mode == lcc_pkg::MODE_TO_NORM)
                    begin
                        mode_next = lcc_pkg::MODE_NORMAL;
                    end
                end
            end
            else
            begin
                // Unscaled samples go through the multiplier at unity gain.
                eff_gain_next = sample_zero ? '0 : lcc_pkg::GAIN_UNITY;
                case (mode_reg)
                    lcc_pkg::MODE_CATCH_UP:
                    begin
                        phase_next = tick_end ? '0 : tick_rest;
                        armed_next = !tick_end;
                        if (tick_end)
                        begin
                            mode_next = lcc_pkg::MODE_TO_NORM;
                            rt_next   = 1'b1;
                        end
                    end
                    lcc_pkg::MODE_FADE_IN:
                    begin
                        muted_next = 1'b0;
                        phase_next = tick_end ? '0 : tick_rest;
                        armed_next = !tick_end;
                        if (tick_end)
                        begin
                            mode_next = lcc_pkg::MODE_NORMAL;
                        end
                        else
                        begin
                            gain_next     = gain_up;
                            eff_gain_next = gain_up;
                        end
                    end
                    lcc_pkg::MODE_FADE_OUT:
                    begin
                        if (tick_end)
                        begin
                            eff_gain_next = '0;
                            muted_next    = 1'b1;
                            phase_next    = fade_length_reg;
                            armed_next    = 1'b1;
                            mode_next     = lcc_pkg::MODE_CATCH_UP;
                            rt_next       = 1'b1;
                            rtc_next      = 1'b1;
                        end
                        else
                        begin
                            phase_next    = tick_rest;
                            armed_next    = 1'b1;
                            gain_next     = gain_dn;
                            eff_gain_next = sample_zero ? '0 : gain_dn;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
        else if (cfg_we)
        begin
            // Preset registers load straight into the voice state.
            case (cfg_index)
                lcc_pkg::CFG_FADE_LENGTH: fade_length_next = cfg_data[lcc_pkg::LEN_W-1:0];
                lcc_pkg::CFG_FADE_STEP:   fade_step_next   = cfg_data[GW-1:0];
                lcc_pkg::CFG_START_QUIET: muted_next       = cfg_data[0];
                lcc_pkg::CFG_INIT_FREQ:
                begin
                    held_freq_next = cfg_data[FW-1:0];
                    prev_freq_next = cfg_data[FW-1:0];
                end
                lcc_pkg::CFG_INIT_VEL:    held_vel_next    = cfg_data[lcc_pkg::VEL_W-1:0];
                lcc_pkg::CFG_INIT_GLIDE:  held_glide_next  = cfg_data[0];
                lcc_pkg::CFG_INIT_KEY:    held_key_next    = cfg_data[lcc_pkg::KEY_W-1:0];
                default:                  fade_step_next   = fade_step_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= lcc_pkg::MODE_NORMAL;
            muted_reg       <= lcc_pkg::RST_QUIET;
            armed_reg       <= 1'b0;
            phase_reg       <= '0;
            gain_reg        <= '0;
            held_freq_reg   <= lcc_pkg::RST_FREQ;
            held_vel_reg    <= lcc_pkg::RST_VELOCITY;
            held_glide_reg  <= lcc_pkg::RST_GLIDE;
            held_key_reg    <= lcc_pkg::RST_KEY;
            prev_freq_reg   <= lcc_pkg::RST_FREQ;
            fade_length_reg <= lcc_pkg::RST_FADE_LENGTH;
            fade_step_reg   <= lcc_pkg::RST_FADE_STEP;
            eff_gain_reg    <= '0;
            fs_reg          <= 1'b0;
            rt_reg          <= 1'b0;
            rtc_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            muted_reg       <= muted_next;
            armed_reg       <= armed_next;
            phase_reg       <= phase_next;
            gain_reg        <= gain_next;
            held_freq_reg   <= held_freq_next;
            held_vel_reg    <= held_vel_next;
            held_glide_reg  <= held_glide_next;
            held_key_reg    <= held_key_next;
            prev_freq_reg   <= prev_freq_next;
            fade_length_reg <= fade_length_next;
            fade_step_reg   <= fade_step_next;
            eff_gain_reg    <= eff_gain_next;
            fs_reg          <= fs_next;
            rt_reg          <= rt_next;
            rtc_reg         <= rtc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_func_reg  <= func;
            item_left_reg  <= sample_left;
            item_right_reg <= sample_right;
            item_freq_reg  <= new_freq;
            item_vel_reg   <= new_velocity;
            item_glide_reg <= new_glide;
            item_key_reg   <= new_key;
            item_ext_reg   <= external;
        end

        if (cmd.square)
        begin
            sq_reg <= held_freq_reg * held_freq_reg;
        end

        if (cmd.div_init)
        begin
            sat_reg     <= (prev_freq_reg == '0) || (sq_reg[lcc_pkg::SQ_W-1:FW] >= prev_freq_reg);
            rem_reg     <= sq_reg[lcc_pkg::SQ_W-1:FW];
            low_reg     <= sq_reg[FW-1:0];
            quot_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= div_fits ? div_diff[FW-1:0] : div_shift[FW-1:0];
            low_reg     <= {low_reg[FW-2:0], 1'b0};
            quot_reg    <= {quot_reg[FW-2:0], div_fits};
            div_cnt_reg <= div_cnt_reg + lcc_pkg::DIV_CNT_W'(1);
        end

        if (cmd.mul)
        begin
            prod_left_reg  <= item_left_reg * gain_signed;
            prod_right_reg <= item_right_reg * gain_signed;
        end

        if (cmd.finish)
        begin
            out_left        <= clip(prod_left_reg);
            out_right       <= clip(prod_right_reg);
            fade_started    <= fs_reg;
            retrigger       <= rt_reg;
            retrig_freq     <= rt_reg ? (rtc_reg ? catch_freq : held_freq_reg) : '0;
            retrig_velocity <= rt_reg ? held_vel_reg : '0;
            retrig_glide    <= rt_reg && held_glide_reg;
            retrig_key      <= rt_reg ? held_key_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/legato_crossfade_controller_unit.sv]
`timescale 1ns / 1ps

// Legato cross-fade controller for one synth voice.
// The items channel carries one word per note update (func 0) or stereo
// sample (func 1); the results channel returns exactly one word per item,
// in order. The configuration port writes register cfg_index with cfg_data
// whenever cfg_we is high except in the decide step; write only while no
// item is in flight. A word is accepted in the idle state, passes the
// decide and multiply steps, and its result is loaded into the output
// register in the finish step. The sample that ends a fade-out computes the
// catch-up frequency with a 32x32 squarer and a restoring divider that
// produces one quotient bit per cycle, before the multiply step.
// The block works on one item at a time; the output register lets it take
// the next word while the previous result waits. If the receiver stalls,
// the result holds and the next item waits in its last step until the
// output register frees up.
// Reset restores the default configuration and puts the voice in normal
// mode with the preset note, unmuted, at zero gain.
module legato_crossfade_controller_unit #(
    parameter int SAMPLE_WIDTH = lcc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lcc_in_if.sink                          items,
    lcc_out_if.source                       results,
    input  logic                            cfg_we,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lcc_pkg::cmd_t    cmd;
    lcc_pkg::status_t status;

    assign items.ready = cmd.in_ready;

    lcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .status   (status),
        .cmd      (cmd)
    );

    lcc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .func            (items.func),
        .sample_left     (items.sample_left),
        .sample_right    (items.sample_right),
        .new_freq        (items.new_freq),
        .new_velocity    (items.new_velocity),
        .new_glide       (items.new_glide),
        .new_key         (items.new_key),
        .external        (items.external),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (results.valid),
        .out_ready       (results.ready),
        .out_left        (results.out_left),
        .out_right       (results.out_right),
        .fade_started    (results.fade_started),
        .retrigger       (results.retrigger),
        .retrig_freq     (results.retrig_freq),
        .retrig_velocity (results.retrig_velocity),
        .retrig_glide    (results.retrig_glide),
        .retrig_key      (results.retrig_key)
    );

`ifndef ASSERT_OFF
    // Only one item is in flight: accepting a word closes the input.
    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("input accepted while an item is in flight");

    // The last step always hands its word to the output register.
    a_finish_shows : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> results.valid)
        else $error("finished item did not reach the output");

    // A fade-out start comes from a note update, which carries silence only.
    a_update_word : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.fade_started |->
            !results.retrigger && results.out_left == '0 && results.out_right == '0)
        else $error("note update word carries sample or retrigger data");

    // Without a retrigger request the note fields are cleared.
    a_retrig_clear : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.retrigger |->
            results.retrig_freq == '0 && results.retrig_velocity == '0 &&
            !results.retrig_glide && results.retrig_key == '0)
        else $error("retrigger fields set without a retrigger");
`endif

endmodule

[bench/legato_crossfade_controller_unit_tb.sv]
`timescale 1ns / 1ps

module legato_crossfade_controller_unit_tb;

    localparam int SW = lcc_pkg::SAMPLE_WIDTH_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic                          func;
        logic signed [SW-1:0]          sample_left;
        logic signed [SW-1:0]          sample_right;
        logic [lcc_pkg::FREQ_W-1:0]    new_freq;
        logic [lcc_pkg::VEL_W-1:0]     new_velocity;
        logic                          new_glide;
        logic [lcc_pkg::KEY_W-1:0]     new_key;
        logic                          external;
    } in_word_t;

    typedef struct packed {
        logic signed [SW-1:0]          out_left;
        logic signed [SW-1:0]          out_right;
        logic                          fade_started;
        logic                          retrigger;
        logic [lcc_pkg::FREQ_W-1:0]    retrig_freq;
        logic [lcc_pkg::VEL_W-1:0]     retrig_velocity;
        logic                          retrig_glide;
        logic [lcc_pkg::KEY_W-1:0]     retrig_key;
    } res_word_t;

    class voice_scoreboard;
        logic [lcc_pkg::LEN_W-1:0]  fade_length;
        logic [lcc_pkg::GAIN_W-1:0] fade_step;
        logic                       start_quiet;
        logic [lcc_pkg::FREQ_W-1:0] init_freq;
        logic [lcc_pkg::VEL_W-1:0]  init_velocity;
        logic                       init_glide;
        logic [lcc_pkg::KEY_W-1:0]  init_key;

        lcc_pkg::mode_t             mode;
        logic                       muted;
        logic                       armed;
        logic [lcc_pkg::LEN_W-1:0]  phase_left;
        logic [lcc_pkg::GAIN_W-1:0] gain;
        logic [lcc_pkg::FREQ_W-1:0] held_freq;
        logic [lcc_pkg::FREQ_W-1:0] prev_freq;
        logic [lcc_pkg::VEL_W-1:0]  held_velocity;
        logic                       held_glide;
        logic [lcc_pkg::KEY_W-1:0]  held_key;

        res_word_t expected_words[$];
        int        errors;
        int        results_seen;

        function new();
            fade_length   = lcc_pkg::RST_FADE_LENGTH;
            fade_step     = lcc_pkg::RST_FADE_STEP;
            start_quiet   = lcc_pkg::RST_QUIET;
            init_freq     = lcc_pkg::RST_FREQ;
            init_velocity = lcc_pkg::RST_VELOCITY;
            init_glide    = lcc_pkg::RST_GLIDE;
            init_key      = lcc_pkg::RST_KEY;
            mode          = lcc_pkg::MODE_NORMAL;
            muted         = lcc_pkg::RST_QUIET;
            armed         = 1'b0;
            phase_left    = '0;
            gain          = '0;
            held_freq     = lcc_pkg::RST_FREQ;
            prev_freq     = lcc_pkg::RST_FREQ;
            held_velocity = lcc_pkg::RST_VELOCITY;
            held_glide    = lcc_pkg::RST_GLIDE;
            held_key      = lcc_pkg::RST_KEY;
            errors        = 0;
            results_seen  = 0;
        endfunction

        // Preset registers take effect on the voice state at once.
        function void write_reg(lcc_pkg::cfg_index_t idx, logic [lcc_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                lcc_pkg::CFG_FADE_LENGTH: fade_length = v[lcc_pkg::LEN_W-1:0];
                lcc_pkg::CFG_FADE_STEP:   fade_step = v[lcc_pkg::GAIN_W-1:0];
                lcc_pkg::CFG_START_QUIET:
                begin
                    start_quiet = v[0];
                    muted = v[0];
                end
                lcc_pkg::CFG_INIT_FREQ:
                begin
                    init_freq = v[lcc_pkg::FREQ_W-1:0];
                    held_freq = v[lcc_pkg::FREQ_W-1:0];
                    prev_freq = v[lcc_pkg::FREQ_W-1:0];
                end
                lcc_pkg::CFG_INIT_VEL:
                begin
                    init_velocity = v[lcc_pkg::VEL_W-1:0];
                    held_velocity = v[lcc_pkg::VEL_W-1:0];
                end
                lcc_pkg::CFG_INIT_GLIDE:
                begin
                    init_glide = v[0];
                    held_glide = v[0];
                end
                lcc_pkg::CFG_INIT_KEY:
                begin
                    init_key = v[lcc_pkg::KEY_W-1:0];
                    held_key = v[lcc_pkg::KEY_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function bit phase_expired();
            if (!armed)
            begin
                phase_left = fade_length;
                armed = 1'b1;
            end
            if (phase_left <= 1)
            begin
                phase_left = '0;
                armed = 1'b0;
                return 1'b1;
            end
            phase_left = phase_left - 1'b1;
            return 1'b0;
        endfunction

        function logic [lcc_pkg::FREQ_W-1:0] catch_up_freq();
            logic [lcc_pkg::SQ_W-1:0] sq;
            logic [lcc_pkg::SQ_W-1:0] quo;
            if (prev_freq == '0)
                return '1;
            sq = lcc_pkg::SQ_W'(held_freq) * lcc_pkg::SQ_W'(held_freq);
            quo = sq / lcc_pkg::SQ_W'(prev_freq);
            if (quo[lcc_pkg::SQ_W-1:lcc_pkg::FREQ_W] != '0)
                return '1;
            return quo[lcc_pkg::FREQ_W-1:0];
        endfunction

        // Floor of sample times gain over 2^16, clamped to the sample range.
        function logic signed [SW-1:0] apply_gain(logic signed [SW-1:0] s);
            longint prod;
            longint q;
            prod = longint'(s) * longint'(gain);
            q = prod >>> lcc_pkg::GAIN_FRAC;
            if (q > longint'(SMAX))
                return SMAX;
            if (q < longint'(SMIN))
                return SMIN;
            return q[SW-1:0];
        endfunction

        function void note_word(in_word_t w);
            res_word_t r;
            logic signed [SW-1:0] l;
            logic signed [SW-1:0] rt;
            logic [lcc_pkg::GAIN_W:0] raised;
            r = '0;
            if (!w.func)
            begin
                if (w.external)
                    mode = lcc_pkg::MODE_NORMAL;
                if (mode != lcc_pkg::MODE_CATCH_UP)
                begin
                    prev_freq = held_freq;
                    held_freq = w.new_freq;
                    held_velocity = w.new_velocity;
                    held_glide = w.new_glide;
                    held_key = w.new_key;
                    if (mode == lcc_pkg::MODE_NORMAL)
                    begin
                        if (muted)
                        begin
                            gain = '0;
                            mode = lcc_pkg::MODE_FADE_IN;
                        end
                        else
                        begin
                            gain = lcc_pkg::GAIN_UNITY;
                            mode = lcc_pkg::MODE_FADE_OUT;
                            r.fade_started = 1'b1;
                        end
                    end
                    else if (mode == lcc_pkg::MODE_TO_NORM)
                        mode = lcc_pkg::MODE_NORMAL;
                end
            end
            else
            begin
                l = w.sample_left;
                rt = w.sample_right;
                if (muted && mode != lcc_pkg::MODE_FADE_IN)
                begin
                    l = '0;
                    rt = '0;
                end
                case (mode)
                    lcc_pkg::MODE_CATCH_UP:
                        if (phase_expired())
                        begin
                            mode = lcc_pkg::MODE_TO_NORM;
                            r.retrigger = 1'b1;
                            r.retrig_freq = held_freq;
                            r.retrig_velocity = held_velocity;
                            r.retrig_glide = held_glide;
                            r.retrig_key = held_key;
                        end
                    lcc_pkg::MODE_FADE_IN:
                    begin
                        muted = 1'b0;
                        if (phase_expired())
                            mode = lcc_pkg::MODE_NORMAL;
                        else
                        begin
                            raised = {1'b0, gain} + {1'b0, fade_step};
                            gain = (raised > lcc_pkg::GAIN_MAX) ? lcc_pkg::GAIN_MAX
                                                                : raised[lcc_pkg::GAIN_W-1:0];
                            l = apply_gain(l);
                            rt = apply_gain(rt);
                        end
                    end
                    lcc_pkg::MODE_FADE_OUT:
                        if (phase_expired())
                        begin
                            l = '0;
                            rt = '0;
                            muted = 1'b1;
                            phase_left = fade_length;
                            armed = 1'b1;
                            mode = lcc_pkg::MODE_CATCH_UP;
                            r.retrigger = 1'b1;
                            r.retrig_freq = catch_up_freq();
                            r.retrig_velocity = held_velocity;
                            r.retrig_glide = held_glide;
                            r.retrig_key = held_key;
                        end
                        else
                        begin
                            gain = (gain > fade_step) ? gain - fade_step : '0;
                            l = apply_gain(l);
                            rt = apply_gain(rt);
                        end
                    default: ;
                endcase
                r.out_left = l;
                r.out_right = rt;
            end
            expected_words.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [lcc_pkg::FREQ_W-1:0] got,
                           logic [lcc_pkg::FREQ_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %h, expected %h",
                                 results_seen, name, got, want));
        endtask

        task check_result(res_word_t got);
            res_word_t want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                results_seen++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("out_left", 32'(got.out_left), 32'(want.out_left));
            compare_field("out_right", 32'(got.out_right), 32'(want.out_right));
            compare_field("fade_started", 32'(got.fade_started), 32'(want.fade_started));
            compare_field("retrigger", 32'(got.retrigger), 32'(want.retrigger));
            compare_field("retrig_freq", got.retrig_freq, want.retrig_freq);
            compare_field("retrig_velocity", 32'(got.retrig_velocity),
                          32'(want.retrig_velocity));
            compare_field("retrig_glide", 32'(got.retrig_glide), 32'(want.retrig_glide));
            compare_field("retrig_key", 32'(got.retrig_key), 32'(want.retrig_key));
            results_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data;

    int send_idle = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    voice_scoreboard sb;

    lcc_in_if #(.SAMPLE_WIDTH(SW)) items_ch ();
    lcc_out_if #(.SAMPLE_WIDTH(SW)) results_ch ();

    legato_crossfade_controller_unit #(.SAMPLE_WIDTH(SW)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch),
        .results(results_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        results_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : observe
        in_word_t w;
        res_word_t r;
        bit moved;
        if (rst_n)
        begin
            moved = cfg_we;
            if (items_ch.valid && items_ch.ready)
            begin
                w.func = items_ch.func;
                w.sample_left = items_ch.sample_left;
                w.sample_right = items_ch.sample_right;
                w.new_freq = items_ch.new_freq;
                w.new_velocity = items_ch.new_velocity;
                w.new_glide = items_ch.new_glide;
                w.new_key = items_ch.new_key;
                w.external = items_ch.external;
                sb.note_word(w);
                moved = 1'b1;
            end
            if (results_ch.valid && results_ch.ready)
            begin
                r.out_left = results_ch.out_left;
                r.out_right = results_ch.out_right;
                r.fade_started = results_ch.fade_started;
                r.retrigger = results_ch.retrigger;
                r.retrig_freq = results_ch.retrig_freq;
                r.retrig_velocity = results_ch.retrig_velocity;
                r.retrig_glide = results_ch.retrig_glide;
                r.retrig_key = results_ch.retrig_key;
                sb.check_result(r);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(9))
            0: return SMAX;
            1: return SMIN;
            default: return SW'($urandom);
        endcase
    endfunction

    // Nearby frequencies keep the catch-up quotient in range; the rest
    // exercise overflow and a zero divisor.
    function automatic logic [lcc_pkg::FREQ_W-1:0] rand_freq();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return $urandom;
            default: return 32'd1000000 + $urandom_range(3000000);
        endcase
    endfunction

    function automatic in_word_t rand_word(bit f);
        in_word_t w;
        w.func = f;
        w.sample_left = rand_sample();
        w.sample_right = rand_sample();
        w.new_freq = rand_freq();
        w.new_velocity = lcc_pkg::VEL_W'($urandom);
        w.new_glide = 1'($urandom_range(1));
        w.new_key = lcc_pkg::KEY_W'($urandom);
        w.external = ($urandom_range(4) == 0);
        return w;
    endfunction

    function automatic in_word_t make_word(bit f, logic signed [SW-1:0] l,
                                           logic signed [SW-1:0] r,
                                           logic [lcc_pkg::FREQ_W-1:0] freq,
                                           logic [lcc_pkg::VEL_W-1:0] vel, bit glide,
                                           logic [lcc_pkg::KEY_W-1:0] key, bit ext);
        in_word_t w;
        w.func = f;
        w.sample_left = l;
        w.sample_right = r;
        w.new_freq = freq;
        w.new_velocity = vel;
        w.new_glide = glide;
        w.new_key = key;
        w.external = ext;
        return w;
    endfunction

    // Called just after a rising edge; returns just after the edge that took the word.
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle)
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid <= 1'b1;
        items_ch.func <= w.func;
        items_ch.sample_left <= w.sample_left;
        items_ch.sample_right <= w.sample_right;
        items_ch.new_freq <= w.new_freq;
        items_ch.new_velocity <= w.new_velocity;
        items_ch.new_glide <= w.new_glide;
        items_ch.new_key <= w.new_key;
        items_ch.external <= w.external;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        items_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_words.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(lcc_pkg::cfg_index_t idx, logic [lcc_pkg::CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    // Mostly whole note sequences: an update followed by, for short fade lengths,
    // enough samples to run through the fade and catch-up, with stray words mixed in.
    task automatic run_random(int count, int len);
        int done;
        int pick;
        int tail;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                drain_results();
            else if (pick < 73)
            begin
                send_word(rand_word(1'b0));
                if (len > 100)
                    tail = $urandom_range(20);
                else if ($urandom_range(2) != 0)
                    tail = 2 * len + $urandom_range(3);
                else
                    tail = $urandom_range(2 * len + 3);
                repeat (tail) send_word(rand_word(1'b1));
                done += 1 + tail;
            end
            else
            begin
                send_word(rand_word($urandom_range(1)));
                done++;
            end
        end
    endtask

    initial
    begin
        int len_tab[8];
        int step_tab[8];
        int idle_tab[8];
        int stall_tab[8];
        int p;
        len_tab = '{1, 2, 5, 4, 7, 3, 6, 65535};
        step_tab = '{65536, 1, 0, 16384, 9362, 21845, 10923, 1};
        idle_tab = '{0, 56, 0, 20, 56, 0, 20, 0};
        stall_tab = '{0, 0, 56, 20, 0, 56, 20, 0};
        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        items_ch.valid <= 1'b0;
        items_ch.func <= 1'b0;
        items_ch.sample_left <= '0;
        items_ch.sample_right <= '0;
        items_ch.new_freq <= '0;
        items_ch.new_velocity <= '0;
        items_ch.new_glide <= 1'b0;
        items_ch.new_key <= '0;
        items_ch.external <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: unscaled samples, then a fade-out from the preset note.
        send_word(make_word(1'b1, SMAX, SMIN, '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b1, SW'(-1), '0, '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b0, '0, '0, '0, '0, 1'b0, '0, 1'b0));
        drain_results();
        cfg_write(lcc_pkg::CFG_FADE_LENGTH, 3);
        cfg_write(lcc_pkg::CFG_FADE_STEP, 65536);
        cfg_we <= 1'b0;
        send_word(make_word(1'b1, SMAX, SMIN, '0, '0, 1'b0, '0, 1'b0));
        // External update mid-fade keeps the running count; the stored zero
        // frequency becomes the catch-up divisor.
        send_word(make_word(1'b0, '0, '0, '1, '1, 1'b1, 7'd127, 1'b1));
        send_word(make_word(1'b1, SMAX, SMAX, '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b1, SMIN, SMIN, '0, '0, 1'b0, '0, 1'b0));
        // Updates during catch-up are dropped.
        send_word(make_word(1'b0, '0, '0, 32'd1234, 16'd5, 1'b0, 7'd3, 1'b0));
        repeat (3) send_word(make_word(1'b1, SMAX, SMIN, '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b1, SW'(1), SW'(-1), '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b0, '0, '0, 32'h0010_0000, 16'd100, 1'b0, 7'd60, 1'b0));
        send_word(make_word(1'b0, '0, '0, 32'h0020_0000, 16'd200, 1'b1, 7'd64, 1'b0));
        // Fade-in with a full step reaches the gain ceiling and clips.
        send_word(make_word(1'b1, SMAX, SMIN, '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b1, SMAX, SMIN, '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b1, SW'(12345), SW'(-12345), '0, '0, 1'b0, '0, 1'b0));
        send_word(make_word(1'b0, '0, '0, 32'hFFFF_F000, 16'd7, 1'b0, 7'd100, 1'b0));
        repeat (3) send_word(make_word(1'b1, SMIN, SMAX, '0, '0, 1'b0, '0, 1'b0));

        // The long fade length runs last, since an armed count outlives the phase.
        for (p = 0; p < 8; p++)
        begin
            drain_results();
            send_idle = idle_tab[p];
            stall_pct = stall_tab[p];
            cfg_write(lcc_pkg::CFG_FADE_LENGTH, len_tab[p]);
            cfg_write(lcc_pkg::CFG_FADE_STEP, step_tab[p]);
            cfg_write(lcc_pkg::CFG_START_QUIET, 32'(p % 2 == 0));
            if (p == 0)
            begin
                cfg_write(lcc_pkg::CFG_INIT_FREQ, '0);
                cfg_write(lcc_pkg::CFG_INIT_VEL, '0);
                cfg_write(lcc_pkg::CFG_INIT_GLIDE, 0);
                cfg_write(lcc_pkg::CFG_INIT_KEY, 0);
            end
            else if (p == 1)
            begin
                cfg_write(lcc_pkg::CFG_INIT_FREQ, 32'hFFFF_FFFF);
                cfg_write(lcc_pkg::CFG_INIT_VEL, 32'hFFFF);
                cfg_write(lcc_pkg::CFG_INIT_GLIDE, 1);
                cfg_write(lcc_pkg::CFG_INIT_KEY, 127);
            end
            else
            begin
                cfg_write(lcc_pkg::CFG_INIT_FREQ, rand_freq());
                cfg_write(lcc_pkg::CFG_INIT_VEL, $urandom_range(65535));
                cfg_write(lcc_pkg::CFG_INIT_GLIDE, $urandom_range(1));
                cfg_write(lcc_pkg::CFG_INIT_KEY, $urandom_range(127));
            end
            cfg_we <= 1'b0;
            run_random((p == 7) ? 50 : 240, len_tab[p]);
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/core/lcc_pkg.sv
rtl/core/lcc_channels.sv
rtl/core/lcc_ctrl.sv
rtl/core/lcc_datapath.sv
rtl/core/legato_crossfade_controller_unit.sv
bench/legato_crossfade_controller_unit_tb.sv
